@@ rtl/cvfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvfs_pkg - shared types and constants for the cell voltage frame decoder
// item types, pipeline entry, charge table and queue sizing
// ----------------------------------------------------------------------------
package cvfs_pkg;

  // default cell count of a frame
  localparam int NUM_CELLS_DEF = 10;

  // result queue, a power of two so the pointers wrap on their own
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // average = (total * 10 * RECIP) >> RECIP_SHIFT, exact for totals below 2^20
  localparam int RECIP_SHIFT = 28;

  // floor(d / 3) = (d * THIRD_MUL) >> THIRD_SHIFT for d up to 3000
  localparam logic [14:0] THIRD_MUL   = 15'd21846;
  localparam int          THIRD_SHIFT = 16;

  // result kinds
  localparam logic KIND_CELL    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // charge table, 0.1 mV -> 0.01 %
  localparam int SOC_POINTS = 10;
  localparam int SOC_SEGS   = SOC_POINTS - 1;

  localparam logic [15:0] SOC_VOLT [SOC_POINTS] = '{
    16'd30000, 16'd33000, 16'd34000, 16'd35000, 16'd36000,
    16'd37000, 16'd38000, 16'd39000, 16'd40000, 16'd42000
  };
  localparam logic [13:0] SOC_CP [SOC_POINTS] = '{
    14'd0,    14'd1000, 14'd2000, 14'd3000, 14'd5000,
    14'd6000, 14'd7000, 14'd8000, 14'd9000, 14'd10000
  };

  localparam logic [13:0] CHARGE_MAX = 14'd10000;

  // slope of each segment as charge step over voltage step
  typedef enum logic [1:0] {
    SCALE_THIRD = 2'd0,
    SCALE_ONE   = 2'd1,
    SCALE_TWO   = 2'd2,
    SCALE_HALF  = 2'd3
  } scale_t;

  localparam scale_t SOC_SCALE [SOC_SEGS] = '{
    SCALE_THIRD, SCALE_ONE, SCALE_ONE, SCALE_TWO, SCALE_ONE,
    SCALE_ONE,   SCALE_ONE, SCALE_ONE, SCALE_HALF
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  cell_index;
    logic [15:0] cell_millivolts;
    logic [19:0] total_millivolts;
    logic [13:0] charge_centipercent;
    logic        last;
  } out_item_t;

  // one completed cell reading, plus the pack summary when has_sum is set
  typedef struct packed {
    logic [3:0]  cell_index;
    logic [15:0] cell_millivolts;
    logic        has_sum;
    logic [19:0] total_millivolts;
    logic [13:0] charge_centipercent;
  } entry_t;

  typedef struct packed {
    logic   vld;
    entry_t entry;
  } stage_t;

endpackage
`default_nettype wire

@@ rtl/cvfs_frame.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvfs_frame - frame byte tracker
// pairs bytes into cell readings, keeps the pack total and the queue credit
// ----------------------------------------------------------------------------
module cvfs_frame #(
  parameter int NUM_CELLS = cvfs_pkg::NUM_CELLS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  cvfs_pkg::in_item_t in_item,
  input  wire                pop,
  output cvfs_pkg::stage_t   stage_o
);
  import cvfs_pkg::*;

  localparam logic [3:0] LAST_CELL = 4'(NUM_CELLS - 1);

  logic [4:0]       pos_r, pos_nxt, pos_eff;
  logic [7:0]       low_r, low_nxt;
  logic [19:0]      total_r, total_nxt, total_eff, sum;
  logic [CNT_W-1:0] credit_r, credit_nxt;
  logic             vld_r;
  entry_t           entry_r, entry_nxt;
  logic             in_acc, take, is_last;
  logic [3:0]       cell_idx;
  logic [15:0]      mv;

  assign in_stall = (credit_r == CNT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    pos_eff   = in_item.frame_start ? 5'd0 : pos_r;
    total_eff = in_item.frame_start ? 20'd0 : total_r;
    cell_idx  = pos_eff[4:1];
    mv        = {in_item.data_byte, low_r};
    sum       = total_eff + 20'(mv);
    is_last   = (cell_idx >= LAST_CELL);
    take      = in_acc & pos_eff[0];

    pos_nxt   = pos_r;
    low_nxt   = low_r;
    total_nxt = total_r;
    if (in_acc) begin
      if (!pos_eff[0]) begin
        low_nxt   = in_item.data_byte;
        pos_nxt   = pos_eff + 5'd1;
        total_nxt = total_eff;
      end else if (is_last) begin
        pos_nxt   = 5'd0;
        total_nxt = 20'd0;
      end else begin
        pos_nxt   = pos_eff + 5'd1;
        total_nxt = sum;
      end
    end

    entry_nxt.cell_index          = cell_idx;
    entry_nxt.cell_millivolts     = mv;
    entry_nxt.has_sum             = is_last;
    entry_nxt.total_millivolts    = sum;
    entry_nxt.charge_centipercent = 14'd0;

    credit_nxt = credit_r + CNT_W'(take) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 5'd0;
      low_r    <= 8'd0;
      total_r  <= 20'd0;
      credit_r <= '0;
      vld_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      low_r    <= low_nxt;
      total_r  <= total_nxt;
      credit_r <= credit_nxt;
      vld_r    <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

  assign stage_o = '{vld: vld_r, entry: entry_r};

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CNT_W'(FIFO_DEPTH))
    else $error("queue credit above depth");

  a_summary_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && entry_r.has_sum) |-> (entry_r.cell_index == LAST_CELL))
    else $error("summary not on last cell");
`endif

endmodule
`default_nettype wire

@@ rtl/cvfs_charge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvfs_charge - state of charge pipeline
// average by reciprocal multiply, segment pick, then segment interpolation
// ----------------------------------------------------------------------------
module cvfs_charge #(
  parameter int NUM_CELLS = cvfs_pkg::NUM_CELLS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  cvfs_pkg::stage_t stage_i,
  output cvfs_pkg::stage_t stage_o
);
  import cvfs_pkg::*;

  localparam logic [28:0] RECIP =
    29'(((1 << RECIP_SHIFT) + NUM_CELLS - 1) / NUM_CELLS);

  // average stage
  logic [23:0] tot10;
  logic [52:0] prod;
  logic        s2_vld_r;
  entry_t      s2_entry_r;
  logic [23:0] s2_avg_r;

  // segment stage
  logic        below, above, found;
  logic [3:0]  sel;
  logic [23:0] diff;
  logic        s3_vld_r;
  entry_t      s3_entry_r;
  logic        s3_below_r, s3_above_r;
  logic [13:0] s3_base_r;
  scale_t      s3_scale_r;
  logic [11:0] s3_d_r;

  // interpolation
  logic [26:0] third_prod;
  logic [13:0] scaled, charge;

  assign tot10 = ({4'd0, stage_i.entry.total_millivolts} << 3)
               + ({4'd0, stage_i.entry.total_millivolts} << 1);
  assign prod  = {29'd0, tot10} * {24'd0, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= stage_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_entry_r <= stage_i.entry;
    s2_avg_r   <= prod[51:28];
  end

  // first segment whose upper point is at or above the average
  always_comb begin
    below = (s2_avg_r < 24'(SOC_VOLT[0]));
    found = 1'b0;
    sel   = 4'd0;
    for (int i = 0; i < SOC_SEGS; i++) begin
      if (!found && (s2_avg_r <= 24'(SOC_VOLT[i + 1]))) begin
        found = 1'b1;
        sel   = 4'(i);
      end
    end
    above = ~found;
    diff  = s2_avg_r - 24'(SOC_VOLT[sel]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_entry_r <= s2_entry_r;
    s3_below_r <= below;
    s3_above_r <= above;
    s3_base_r  <= SOC_CP[sel];
    s3_scale_r <= SOC_SCALE[sel];
    s3_d_r     <= diff[11:0];
  end

  assign third_prod = {15'd0, s3_d_r} * {12'd0, THIRD_MUL};

  always_comb begin
    unique case (s3_scale_r)
      SCALE_THIRD: scaled = 14'(third_prod >> THIRD_SHIFT);
      SCALE_ONE:   scaled = {2'd0, s3_d_r};
      SCALE_TWO:   scaled = {1'b0, s3_d_r, 1'b0};
      SCALE_HALF:  scaled = {3'd0, s3_d_r[11:1]};
      default:     scaled = 14'd0;
    endcase

    priority if (s3_below_r) begin
      charge = 14'd0;
    end else if (s3_above_r) begin
      charge = CHARGE_MAX;
    end else begin
      charge = s3_base_r + scaled;
    end

    stage_o.vld                       = s3_vld_r;
    stage_o.entry                     = s3_entry_r;
    stage_o.entry.charge_centipercent = charge;
  end

`ifndef NO_ASSERTIONS
  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_o.vld |-> (stage_o.entry.charge_centipercent <= CHARGE_MAX))
    else $error("charge out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/cvfs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvfs_queue - result queue and output sequencer
// stores one entry per cell and sends its cell item, then its summary item if it has one
// ----------------------------------------------------------------------------
module cvfs_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cvfs_pkg::stage_t    wr_i,
  output logic                out_valid,
  input  wire                 out_stall,
  output cvfs_pkg::out_item_t out_item,
  output logic                pop
);
  import cvfs_pkg::*;

  entry_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fcnt_r;
  logic             sub_r;
  entry_t           head;
  logic             out_acc;

  assign head      = mem[rd_ptr_r];
  assign out_valid = (fcnt_r != '0);
  assign out_acc   = out_valid & ~out_stall;
  // entry leaves after its summary, or after its cell item if it has none
  assign pop       = out_acc & (sub_r | ~head.has_sum);

  always_comb begin
    out_item.kind                = sub_r ? KIND_SUMMARY : KIND_CELL;
    out_item.cell_index          = head.cell_index;
    out_item.cell_millivolts     = sub_r ? 16'd0 : head.cell_millivolts;
    out_item.total_millivolts    = sub_r ? head.total_millivolts : 20'd0;
    out_item.charge_centipercent = sub_r ? head.charge_centipercent : 14'd0;
    out_item.last                = sub_r;
  end

  always_ff @(posedge clk) begin
    if (wr_i.vld) begin
      mem[wr_ptr_r] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (wr_i.vld) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fcnt_r <= fcnt_r + CNT_W'(wr_i.vld) - CNT_W'(pop);
      if (out_acc) begin
        sub_r <= ~pop;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fcnt_r != '0))
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r == CNT_W'(FIFO_DEPTH)) |-> (!wr_i.vld || pop))
    else $error("write into full queue");
`endif

endmodule
`default_nettype wire

@@ rtl/cell_voltage_frame_soc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cell_voltage_frame_soc - battery cell voltage frame decoder
// per-cell millivolt readings, pack total and state of charge per frame
// ----------------------------------------------------------------------------
//
//  channel | ports                       | item
//  --------+-----------------------------+---------------------------------
//  input   | in_valid, in_stall, in_item | one frame byte, frame start flag
//  output  | out_valid, out_stall,       | cell reading or pack summary
//          | out_item                    |
//
// one byte is taken every cycle while in_stall is low; a high byte's cell item
// is queued after the pipeline below; the summary follows it on the last cell
// the pipeline is frame tracker, average multiply, segment pick, interpolation
// reset (rst_n low, synchronous) clears byte position, held byte, total and
// the result queue
// in_stall rises only when the result queue and the pipeline hold
// FIFO_DEPTH cell entries, that is when out_stall has held results back
// ----------------------------------------------------------------------------
module cell_voltage_frame_soc #(
  // cells per frame, 1 to 16
  parameter int NUM_CELLS = cvfs_pkg::NUM_CELLS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cvfs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output cvfs_pkg::out_item_t out_item
);
  import cvfs_pkg::*;

  // completed cell readings, running total attached
  stage_t frame_stage;
  // same entries with the charge filled in, ready for the queue
  stage_t charge_stage;
  // queue releases one entry, credit goes back to the frame tracker
  logic   pop;

  cvfs_frame #(
    .NUM_CELLS (NUM_CELLS)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (pop),
    .stage_o  (frame_stage)
  );

  cvfs_charge #(
    .NUM_CELLS (NUM_CELLS)
  ) u_charge (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage_i (frame_stage),
    .stage_o (charge_stage)
  );

  // cell item first, then the summary of the same entry when it has one
  cvfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (charge_stage),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .pop       (pop)
  );

endmodule
`default_nettype wire
